FILE: rtl/illm_pkg.sv
// ============================================================================
// illm_pkg
// Shared field widths, opcodes and status codes of the linked list manager.
// ============================================================================
`default_nettype none

package illm_pkg;

   // Field widths of the request and response words
   localparam int unsigned OPCODE_W   = 2;
   localparam int unsigned POSITION_W = 6;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned SLOT_W     = 6;
   localparam int unsigned COUNT_W    = 6;

   // Default sizing
   localparam int unsigned DEFAULT_SLOTS       = 64;
   localparam int unsigned DEFAULT_VALUE_WIDTH = 32;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam opcode_type OP_INSERT = 2'd0;
   localparam opcode_type OP_DELETE = 2'd1;
   localparam opcode_type OP_LOCATE = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_RANGE = 2'd2;

endpackage : illm_pkg

`default_nettype wire

FILE: rtl/illm_ifs.sv
// ============================================================================
// illm_ifs
// Valid/ready channels of the linked list manager: request and response.
// ============================================================================
`default_nettype none

interface illm_req_if;
   import illm_pkg::*;

   logic                         valid;
   logic                         ready;
   opcode_type                   opcode;
   logic [POSITION_W-1:0]        position;
   logic signed [VALUE_W-1:0]    value;

   modport source (output valid, opcode, position, value, input ready);
   modport sink   (input valid, opcode, position, value, output ready);
endinterface : illm_req_if

interface illm_rsp_if;
   import illm_pkg::*;

   logic                         valid;
   logic                         ready;
   status_type                   status;
   logic [SLOT_W-1:0]            slot;
   logic signed [VALUE_W-1:0]    element;
   logic [COUNT_W-1:0]           count;

   modport source (output valid, status, slot, element, count, input ready);
   modport sink   (input valid, status, slot, element, count, output ready);
endinterface : illm_rsp_if

`default_nettype wire

FILE: rtl/indexed_linked_list_manager_core.sv
// ============================================================================
// indexed_linked_list_manager_core
// Doubly linked list in slot memories (next, prev, data) with a free chain.
// ============================================================================
//
//   channel   dir  handshake       word contents
//   -------   ---  --------------  -------------------------------------
//   req_bus   in   valid / ready   opcode, position, value
//   rsp_bus   out  valid / ready   status, slot, element, count
//
// An accepted word walks from the sentinel by its position, insert and delete
// then write links in two states; a rejected word skips the walk. The walk
// issues one read of the next-link memory per cycle, each address taken from
// the previous read. Reset clears only registers; never-allocated slots are
// served by a fill mark, so no clearing pass is needed. The block takes a new
// word while the last response sits in the output register; a stalled response
// holds the sequencer in its response state until the register frees up.
// ============================================================================
`default_nettype none

module indexed_linked_list_manager_core #(
   parameter int unsigned SLOTS       = illm_pkg::DEFAULT_SLOTS,
   parameter int unsigned VALUE_WIDTH = illm_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   illm_req_if.sink    req_bus,
   illm_rsp_if.source  rsp_bus
);
   import illm_pkg::*;

   localparam int unsigned IW   = $clog2(SLOTS);              // slot index
   localparam int unsigned CW   = $clog2(SLOTS);              // count, max SLOTS-1
   localparam int unsigned CMPW = (CW > POSITION_W) ? CW : POSITION_W;
   localparam int unsigned SW   = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_INS_A,
      S_INS_B,
      S_DEL_A,
      S_DEL_B,
      S_RESP
   } state_type;

   // ---------------------------------------------------------------------
   // Slot memories, registered read at one shared address: next links, and
   // prev link with value in one word that is written field by field
   // ---------------------------------------------------------------------
   logic [IW-1:0]    next_mem [SLOTS];
   logic [IW+SW-1:0] node_mem [SLOTS];   // {prev, data}

   logic [IW-1:0] mem_raddr;
   logic [IW-1:0] next_q, prev_q;
   logic [SW-1:0] data_q;

   logic          nxt_we,  prv_we,  dat_we;
   logic [IW-1:0] nxt_waddr, nod_waddr;
   logic [IW-1:0] nxt_wdata, prv_wdata;
   logic [SW-1:0] dat_wdata;

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         next_mem[nxt_waddr] <= nxt_wdata;
      end
      next_q <= next_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (prv_we) begin
         node_mem[nod_waddr][IW+SW-1:SW] <= prv_wdata;
      end
      if (dat_we) begin
         node_mem[nod_waddr][SW-1:0] <= dat_wdata;
      end
      {prev_q, data_q} <= node_mem[mem_raddr];
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type       state_ff,      state_in;
   opcode_type      op_ff,         op_in;
   logic [POSITION_W-1:0] left_ff, left_in;      // walk steps still to go
   logic [SW-1:0]   val_ff,        val_in;
   logic [IW-1:0]   rd_addr_ff;                  // address behind next_q
   logic [IW-1:0]   tgt_ff,        tgt_in;       // slot reached by the walk
   logic [IW-1:0]   tnext_ff,      tnext_in;     // its next link
   logic [IW-1:0]   tprev_ff,      tprev_in;     // its prev link
   status_type      res_status_ff, res_status_in;
   logic [IW-1:0]   res_slot_ff,   res_slot_in;
   logic [SW-1:0]   res_elem_ff,   res_elem_in;

   logic [IW-1:0]   free_head_ff,  free_head_in;
   logic [CW-1:0]   count_ff,      count_in;
   logic [IW-1:0]   tail_ff,       tail_in;
   logic [IW:0]     fill_ff,       fill_in;      // slots below this were written

   logic            rsp_valid_ff,  rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]  rsp_slot_ff,  rsp_slot_in;
   logic [VALUE_W-1:0] rsp_elem_ff,  rsp_elem_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   // ---------------------------------------------------------------------
   // Next link as the list sees it: slots never written still hold their
   // reset chain (sentinel to itself, slot i to i+1, last slot to 0).
   // ---------------------------------------------------------------------
   logic [IW-1:0] fresh_next;
   logic [IW-1:0] next_fix;

   always_comb begin
      if (rd_addr_ff == '0 || rd_addr_ff == IW'(SLOTS - 1)) begin
         fresh_next = '0;
      end else begin
         fresh_next = rd_addr_ff + IW'(1);
      end
      next_fix = ({1'b0, rd_addr_ff} >= fill_ff) ? fresh_next : next_q;
   end

   // ---------------------------------------------------------------------
   // Request checks
   // ---------------------------------------------------------------------
   logic [CMPW-1:0] pos_cmp, cnt_cmp;
   logic            req_bad;
   status_type      req_bad_status;
   logic            req_fire;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign pos_cmp       = CMPW'(req_bus.position);
   assign cnt_cmp       = CMPW'(count_ff);

   always_comb begin
      req_bad        = 1'b0;
      req_bad_status = STATUS_OK;
      unique case (req_bus.opcode) inside
         OP_INSERT: begin
            if (free_head_ff == '0 || count_ff == CW'(SLOTS - 1)) begin
               req_bad        = 1'b1;
               req_bad_status = STATUS_FULL;
            end else if (pos_cmp > cnt_cmp) begin
               req_bad        = 1'b1;
               req_bad_status = STATUS_RANGE;
            end
         end
         OP_DELETE, OP_LOCATE: begin
            if (req_bus.position == '0 || pos_cmp > cnt_cmp) begin
               req_bad        = 1'b1;
               req_bad_status = STATUS_RANGE;
            end
         end
         default: begin
            req_bad        = 1'b1;
            req_bad_status = STATUS_RANGE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      left_in       = left_ff;
      val_in        = val_ff;
      tgt_in        = tgt_ff;
      tnext_in      = tnext_ff;
      tprev_in      = tprev_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_elem_in   = res_elem_ff;
      free_head_in  = free_head_ff;
      count_in      = count_ff;
      tail_in       = tail_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_elem_in   = rsp_elem_ff;
      rsp_count_in  = rsp_count_ff;

      mem_raddr = '0;
      nxt_we    = 1'b0;
      nxt_waddr = '0;
      nxt_wdata = '0;
      nod_waddr = '0;
      prv_we    = 1'b0;
      prv_wdata = '0;
      dat_we    = 1'b0;
      dat_wdata = '0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in   = req_bus.opcode;
               left_in = req_bus.position;
               val_in  = req_bus.value[SW-1:0];
               if (req_bad) begin
                  res_status_in = req_bad_status;
                  res_slot_in   = '0;
                  res_elem_in   = '0;
                  state_in      = S_RESP;
               end else begin
                  // walk starts at the sentinel
                  mem_raddr = '0;
                  state_in  = S_WALK;
               end
            end
         end

         S_WALK: begin
            if (left_ff == '0) begin
               // next_q/prev_q/data_q now belong to the addressed slot
               tgt_in        = rd_addr_ff;
               tnext_in      = next_fix;
               tprev_in      = prev_q;
               res_status_in = STATUS_OK;
               unique case (op_ff)
                  OP_INSERT: begin
                     // fetch the link of the slot to be allocated
                     mem_raddr = free_head_ff;
                     state_in  = S_INS_A;
                  end
                  OP_DELETE: begin
                     res_slot_in = rd_addr_ff;
                     res_elem_in = data_q;
                     state_in    = S_DEL_A;
                  end
                  OP_LOCATE: begin
                     res_slot_in = rd_addr_ff;
                     res_elem_in = data_q;
                     state_in    = S_RESP;
                  end
                  default: begin
                     res_status_in = STATUS_RANGE;
                     res_slot_in   = '0;
                     res_elem_in   = '0;
                     state_in      = S_RESP;
                  end
               endcase
            end else begin
               mem_raddr = next_fix;
               left_in   = left_ff - POSITION_W'(1);
            end
         end

         S_INS_A: begin
            // new slot goes behind tgt: link tgt -> new, store value
            nxt_we       = 1'b1;
            nxt_waddr    = tgt_ff;
            nxt_wdata    = free_head_ff;
            nod_waddr    = free_head_ff;
            prv_we       = 1'b1;
            prv_wdata    = tgt_ff;
            dat_we       = 1'b1;
            dat_wdata    = val_ff;
            free_head_in = next_fix;
            if ({1'b0, free_head_ff} >= fill_ff) begin
               fill_in = {1'b0, free_head_ff} + (IW + 1)'(1);
            end
            if (tgt_ff == tail_ff) begin
               tail_in = free_head_ff;
            end
            count_in    = count_ff + CW'(1);
            res_slot_in = free_head_ff;
            res_elem_in = val_ff;
            state_in    = S_INS_B;
         end

         S_INS_B: begin
            // new -> old successor, old successor back to new
            nxt_we    = 1'b1;
            nxt_waddr = res_slot_ff;
            nxt_wdata = tnext_ff;
            nod_waddr = tnext_ff;
            prv_we    = 1'b1;
            prv_wdata = res_slot_ff;
            state_in  = S_RESP;
         end

         S_DEL_A: begin
            // bridge around the removed slot
            nxt_we    = 1'b1;
            nxt_waddr = tprev_ff;
            nxt_wdata = tnext_ff;
            nod_waddr = tnext_ff;
            prv_we    = 1'b1;
            prv_wdata = tprev_ff;
            state_in  = S_DEL_B;
         end

         S_DEL_B: begin
            // push the slot onto the free chain
            nxt_we       = 1'b1;
            nxt_waddr    = res_slot_ff;
            nxt_wdata    = free_head_ff;
            free_head_in = res_slot_ff;
            if (res_slot_ff == tail_ff) begin
               tail_in = tprev_ff;
            end
            count_in = count_ff - CW'(1);
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = SLOT_W'(res_slot_ff);
               rsp_elem_in   = VALUE_W'(res_elem_ff);
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= IW'(1);
         count_ff     <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
      end
      op_ff         <= op_in;
      left_ff       <= left_in;
      val_ff        <= val_in;
      rd_addr_ff    <= mem_raddr;
      tgt_ff        <= tgt_in;
      tnext_ff      <= tnext_in;
      tprev_ff      <= tprev_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_elem_ff   <= res_elem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_elem_ff   <= rsp_elem_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.status  = rsp_status_ff;
   assign rsp_bus.slot    = rsp_slot_ff;
   assign rsp_bus.element = rsp_elem_ff;
   assign rsp_bus.count   = rsp_count_ff;

endmodule : indexed_linked_list_manager_core

`default_nettype wire
